### design/scf_pkg.sv
// Package for the scrambled command frame encoder.
// Holds the queued command record, register codes, the offset table and byte helpers.
// No dependencies.
`default_nettype none

package scf_pkg;

  localparam int unsigned FrameLen = 12;
  localparam logic [7:0] LEN_BYTE = 8'h09;
  localparam logic [7:0] BUMP_LOW = 8'h54;
  localparam logic [7:0] BUMP_HIGH = 8'hD3;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam logic [3:0] POS_LEN = 4'd0;
  localparam logic [3:0] POS_KEY = 4'd1;
  localparam logic [3:0] POS_CHECK = 4'd9;
  localparam logic [3:0] POS_CRC_LO = 4'd10;
  localparam logic [3:0] POS_LAST = 4'(FrameLen - 1);

  typedef enum logic {
    REG_REMOTE_ID = 1'b0,
    REG_REQUEST_TYPE = 1'b1
  } scf_reg_t;

  localparam logic [7:0] OFFS_TAB [8][4] = '{
    '{8'h45, 8'h1F, 8'h14, 8'h5C},
    '{8'h2B, 8'hC9, 8'hE3, 8'h11},
    '{8'h6D, 8'h5F, 8'h8A, 8'h2B},
    '{8'hAF, 8'h03, 8'h1D, 8'hF3},
    '{8'h1A, 8'hE2, 8'hF0, 8'hD1},
    '{8'h04, 8'hD8, 8'h71, 8'h42},
    '{8'hAF, 8'h04, 8'hDD, 8'h07},
    '{8'h61, 8'h13, 8'h38, 8'h64}
  };

  // Plain bytes in frame order: request type, id high, id low, command,
  // argument, sequence, group.
  typedef struct packed {
    logic [7:0]      key;
    logic [7:0]      xm;
    logic [1:0]      col;
    logic            bump;
    logic [6:0][7:0] plain;
  } scf_cmd_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7 - k];
    end
    return r;
  endfunction

  function automatic logic [7:0] key_mask(input logic [7:0] key);
    logic [3:0] lo;
    logic [2:0] x;
    logic [3:0] hi_n;
    logic [3:0] lo_n;
    lo = key[3:0];
    x = key[6:4] + {2'b00, (lo >= 4'd4)} + 3'd6;
    hi_n = (4'd4 + {1'b0, x}) ^ 4'd1;
    lo_n = (lo + 4'd4) ^ 4'd2;
    return {hi_n, lo_n};
  endfunction

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] v);
    logic [15:0] s;
    logic [7:0]  b;
    s = crc;
    b = v;
    for (int k = 0; k < 8; k++) begin
      if (b[0] ^ s[0]) begin
        s = (s >> 1) ^ CRC_POLY;
      end else begin
        s = s >> 1;
      end
      b = b >> 1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### design/scf_front.sv
// Front end of the frame encoder: takes a command request and classifies its key.
// Depends on scf_pkg.
`default_nettype none

module scf_front
  import scf_pkg::*;
(
  input  wire logic [7:0]  command,
  input  wire logic [7:0]  argument,
  input  wire logic [7:0]  group,
  input  wire logic [7:0]  scramble_key,
  input  wire logic [7:0]  sequence_req,
  input  wire logic [15:0] remote_id,
  input  wire logic [7:0]  request_type,
  output scf_cmd_t         cmd
);

  always_comb begin
    cmd.key = scramble_key;
    cmd.xm = key_mask(scramble_key);
    cmd.col = scramble_key[1:0];
    cmd.bump = (scramble_key >= BUMP_LOW) && (scramble_key <= BUMP_HIGH);
    cmd.plain[0] = request_type;
    cmd.plain[1] = remote_id[15:8];
    cmd.plain[2] = remote_id[7:0];
    cmd.plain[3] = command;
    cmd.plain[4] = argument;
    cmd.plain[5] = sequence_req;
    cmd.plain[6] = group;
  end

endmodule

`default_nettype wire

### design/scf_queue.sv
// Two-entry queue of classified command requests between front and back end.
// Depends on scf_pkg.
`default_nettype none

module scf_queue
  import scf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire scf_cmd_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output scf_cmd_t      head
);

  scf_cmd_t   entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### design/scf_back.sv
// Back end of the frame encoder: walks the twelve frame positions of the head request,
// scrambles the payload, keeps the checksum and CRC, and drives the output register.
// Depends on scf_pkg.
`default_nettype none

module scf_back
  import scf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire scf_cmd_t   head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [3:0]      out_pos,
  output logic            out_last
);

  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic [3:0]  out_pos_r;
  logic        out_last_r;
  logic        advance;
  logic [3:0]  row_full;
  logic [2:0]  row;
  logic [7:0]  plain_b;
  logic [7:0]  frame_b;

  assign advance = head_valid && (!out_valid_r || out_ready);
  assign pop = advance && (pos_r == POS_LAST);
  assign row_full = pos_r - 4'd2;
  assign row = row_full[2:0];
  assign plain_b = head.plain[row];

  always_comb begin
    case (pos_r)
      POS_LEN: frame_b = LEN_BYTE;
      POS_KEY: frame_b = head.key;
      POS_CHECK: frame_b = ((head.xm + sum_r + 8'd2) ^ head.xm) + OFFS_TAB[7][head.col];
      POS_CRC_LO: frame_b = crc_r[7:0];
      POS_LAST: frame_b = crc_r[15:8];
      default: frame_b = (plain_b ^ head.xm) + OFFS_TAB[row][head.col] + {head.bump, 7'd0};
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    sum_nxt = sum_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      if (pos_r == POS_LAST) begin
        pos_nxt = 4'd0;
        crc_nxt = 16'd0;
        sum_nxt = 8'd0;
      end else begin
        pos_nxt = pos_r + 4'd1;
        if (pos_r < POS_CRC_LO) begin
          crc_nxt = crc_update(crc_r, frame_b);
        end
        if ((pos_r > POS_KEY) && (pos_r < POS_CHECK)) begin
          sum_nxt = sum_r + plain_b;
        end
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
      crc_r <= 16'd0;
      sum_r <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      sum_r <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= rev8(frame_b);
      out_pos_r <= pos_r;
      out_last_r <= (pos_r == POS_LAST);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_pos = out_pos_r;
  assign out_last = out_last_r;

endmodule

`default_nettype wire

### design/scrambled_command_frame_encoder_top.sv
// Top level of the scrambled command frame encoder with its configuration registers.
// Depends on scf_pkg, scf_front, scf_queue and scf_back.
//
//   Channel  Direction  Moves
//   in_      slave      one command request (command, argument, group, key, sequence)
//   out_     master     one bit-reversed frame byte with its position, tlast on byte 11
//   cfg_     slave      APB writes and reads of the remote id (0x0) and request_type (0x4)
//
// Each request yields twelve bytes, one per cycle while out_tready is high;
// the back end's position counter steps through the positions.
// A taken request is queued first; its bytes then leave via the output register.
// A two-entry queue lets the input side take new requests while a frame is sent.
// Reset is synchronous and active low; the registers return to 0x0532 and 0x45.
`default_nettype none

module scrambled_command_frame_encoder_top
  import scf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command [7:0], argument [15:8], group [23:16], scramble_key [31:24],
  // sequence_req [39:32]
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // frame_byte [7:0]
  output logic [7:0]       out_tdata,
  // byte_position [3:0]
  output logic [3:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [15:0] remote_id_r, remote_id_nxt;
  logic [7:0]  request_type_r, request_type_nxt;
  logic        cfg_wr;
  scf_cmd_t    front_cmd;
  scf_cmd_t    head;
  logic        q_full;
  logic        head_valid;
  logic        pop;
  logic        push;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    remote_id_nxt = remote_id_r;
    request_type_nxt = request_type_r;
    cfg_prdata = 32'd0;
    case (scf_reg_t'(cfg_paddr[2]))
      REG_REMOTE_ID: begin
        cfg_prdata = {16'd0, remote_id_r};
        if (cfg_wr) begin
          remote_id_nxt = cfg_pwdata[15:0];
        end
      end
      REG_REQUEST_TYPE: begin
        cfg_prdata = {24'd0, request_type_r};
        if (cfg_wr) begin
          request_type_nxt = cfg_pwdata[7:0];
        end
      end
      default: cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remote_id_r <= 16'd1330;
      request_type_r <= 8'd69;
    end else begin
      remote_id_r <= remote_id_nxt;
      request_type_r <= request_type_nxt;
    end
  end

  assign in_tready = !q_full;
  assign push = in_tvalid && !q_full;

  scf_front u_front (
    .command      (in_tdata[7:0]),
    .argument     (in_tdata[15:8]),
    .group        (in_tdata[23:16]),
    .scramble_key (in_tdata[31:24]),
    .sequence_req (in_tdata[39:32]),
    .remote_id    (remote_id_r),
    .request_type (request_type_r),
    .cmd          (front_cmd)
  );

  scf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (front_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  scf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_pos    (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

### test/tb_scrambled_command_frame_encoder_top.sv
// Self-checking testbench for scrambled_command_frame_encoder_top.
// It predicts each 12-byte frame from its own copy of the registers and checks bytes in order.
// Depends on scf_pkg and the top level only.
`default_nettype none

module tb_scrambled_command_frame_encoder_top;
  import scf_pkg::*;

  // Field order matches the in_tdata packing, first field in the highest bits.
  typedef struct packed {
    logic [7:0] seq_num;
    logic [7:0] scr_key;
    logic [7:0] group_id;
    logic [7:0] cmd_arg;
    logic [7:0] cmd_code;
  } remote_cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [3:0] byte_pos;
    logic       last_byte;
  } frame_byte_t;

  localparam logic [7:0] FRAME_LENGTH_BYTE = 8'h09;
  localparam logic [7:0] KEY_BUMP_LOW = 8'h54;
  localparam logic [7:0] KEY_BUMP_HIGH = 8'hD3;
  localparam logic [15:0] KERMIT_POLY = 16'h8408;
  localparam logic [7:0] SCRAMBLE_OFFSETS [8][4] = '{
    '{8'h45, 8'h1F, 8'h14, 8'h5C},
    '{8'h2B, 8'hC9, 8'hE3, 8'h11},
    '{8'h6D, 8'h5F, 8'h8A, 8'h2B},
    '{8'hAF, 8'h03, 8'h1D, 8'hF3},
    '{8'h1A, 8'hE2, 8'hF0, 8'hD1},
    '{8'h04, 8'hD8, 8'h71, 8'h42},
    '{8'hAF, 8'h04, 8'hDD, 8'h07},
    '{8'h61, 8'h13, 8'h38, 8'h64}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  remote_cmd_t cmd_pending [$];
  frame_byte_t frame_bytes_due [$];
  logic [15:0] dev_id_cfg = 16'h0532;
  logic [7:0]  req_type_cfg = 8'h45;
  logic        req_taken = 1'b0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_left = 0;
  int          cmds_sent = 0;
  int          bytes_checked = 0;
  int          error_count = 0;

  scrambled_command_frame_encoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] mirror_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7 - k];
    end
    return r;
  endfunction

  function automatic logic [7:0] key_xor_byte(input logic [7:0] k);
    logic [2:0] hi3;
    logic [3:0] hi_nib;
    logic [3:0] lo_nib;
    hi3 = 3'(k[7:4] + 4'(k[3:0] > 4'd3) + 4'd6);
    hi_nib = ({1'b0, hi3} + 4'd4) ^ 4'd1;
    lo_nib = (k[3:0] + 4'd4) ^ 4'd2;
    return {hi_nib, lo_nib};
  endfunction

  function automatic logic [15:0] kermit_crc_byte(input logic [15:0] crc, input logic [7:0] v);
    logic [15:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ v[k]) begin
        c = (c >> 1) ^ KERMIT_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Builds the frame for one command under the current register copy and queues
  // its twelve bit-reversed bytes.
  function automatic void encode_frame(input remote_cmd_t c);
    logic [7:0]  plain [7];
    logic [7:0]  fb [12];
    logic [7:0]  xm;
    logic [7:0]  sum;
    logic [7:0]  bump;
    logic [1:0]  col;
    logic [15:0] crc;
    frame_byte_t e;
    xm = key_xor_byte(c.scr_key);
    col = c.scr_key[1:0];
    bump = (c.scr_key >= KEY_BUMP_LOW && c.scr_key <= KEY_BUMP_HIGH) ? 8'h80 : 8'h00;
    plain = '{req_type_cfg, dev_id_cfg[15:8], dev_id_cfg[7:0], c.cmd_code, c.cmd_arg,
              c.seq_num, c.group_id};
    fb[0] = FRAME_LENGTH_BYTE;
    fb[1] = c.scr_key;
    sum = xm;
    for (int i = 0; i < 7; i++) begin
      sum = sum + plain[i];
      fb[i + 2] = (plain[i] ^ xm) + SCRAMBLE_OFFSETS[i][col] + bump;
    end
    fb[9] = ((sum + 8'd2) ^ xm) + SCRAMBLE_OFFSETS[7][col];
    crc = '0;
    for (int i = 0; i < 10; i++) begin
      crc = kermit_crc_byte(crc, fb[i]);
    end
    fb[10] = crc[7:0];
    fb[11] = crc[15:8];
    for (int i = 0; i < 12; i++) begin
      e.frame_byte = mirror_byte(fb[i]);
      e.byte_pos = 4'(i);
      e.last_byte = (i == 11);
      frame_bytes_due.push_back(e);
    end
  endfunction

  function automatic remote_cmd_t random_cmd();
    logic [7:0]  edge_keys [8] = '{8'h00, 8'h03, 8'h04, 8'h53, 8'h54, 8'hD3, 8'hD4, 8'hFF};
    remote_cmd_t c;
    c = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    if ($urandom_range(3) == 0) begin
      c.scr_key = edge_keys[$urandom_range(7)];
    end
    return c;
  endfunction

  // Request driver: holds a request until it is taken, then offers the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || req_taken) begin
      if (cmd_pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= cmd_pending[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_left > 0) begin
      out_tready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    frame_byte_t due;
    if (rst_n && in_tvalid && in_tready) begin
      encode_frame(cmd_pending.pop_front());
      req_taken = 1'b1;
      cmds_sent++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_bytes_due.size() == 0) begin
        $error("Unexpected frame byte 0x%02h at position %0d", out_tdata, out_tuser);
        error_count++;
      end else begin
        due = frame_bytes_due.pop_front();
        bytes_checked++;
        if (out_tdata !== due.frame_byte) begin
          $error("frame_byte mismatch: expected 0x%02h, got 0x%02h", due.frame_byte, out_tdata);
          error_count++;
        end
        if (out_tuser !== due.byte_pos) begin
          $error("byte_position mismatch: expected %0d, got %0d", due.byte_pos, out_tuser);
          error_count++;
        end
        if (out_tlast !== due.last_byte) begin
          $error("last_byte mismatch: expected %0b, got %0b", due.last_byte, out_tlast);
          error_count++;
        end
      end
    end
  end

  // Writes a register, reads it back and updates the local copy.
  task automatic program_reg(input scf_reg_t r, input logic [15:0] value);
    logic [31:0] rd;
    logic [31:0] want;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(r) << 2;
    cfg_pwdata <= {16'h0000, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (r == REG_REMOTE_ID) begin
      dev_id_cfg = value;
      want = {16'h0000, value};
    end else begin
      req_type_cfg = value[7:0];
      want = {24'h000000, value[7:0]};
    end
    if (rd !== want) begin
      $error("register %s readback mismatch: expected 0x%08h, got 0x%08h", r.name(), want, rd);
      error_count++;
    end
  endtask

  task automatic drain_frames();
    int n;
    n = 0;
    while ((cmd_pending.size() != 0 || in_tvalid || frame_bytes_due.size() != 0) && n < 50000) begin
      @(posedge clk);
      n++;
    end
    if (frame_bytes_due.size() != 0 || cmd_pending.size() != 0) begin
      $error("%0d frame bytes and %0d requests still outstanding", frame_bytes_due.size(),
             cmd_pending.size());
      error_count++;
      frame_bytes_due.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] id, input logic [7:0] rtype, input int gap,
                           input int stall, input int count, input int hold);
    drain_frames();
    program_reg(REG_REMOTE_ID, id);
    program_reg(REG_REQUEST_TYPE, {8'h00, rtype});
    send_gap_pct = gap;
    recv_stall_pct = stall;
    hold_off_left = hold;
    repeat (count) cmd_pending.push_back(random_cmd());
  endtask

  initial begin : stimulus
    logic [7:0] dir_keys [16] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h13, 8'h14, 8'h53,
                                  8'h54, 8'h7F, 8'h80, 8'hD3, 8'hD4, 8'hEC, 8'hF3, 8'hFF};
    logic [7:0] v;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed requests under the reset register values.
    cmd_pending.push_back({8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    cmd_pending.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    cmd_pending.push_back({8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA});
    cmd_pending.push_back({8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
    for (int i = 0; i < 16; i++) begin
      v = 8'(i * 8'h11);
      cmd_pending.push_back({8'(i * 37), dir_keys[i], {4'(i), ~4'(i)}, ~v, v});
    end

    run_phase(16'hFFFF, 8'hFF, 0, 0, 45, 0);
    run_phase(16'h0000, 8'h00, 54, 0, 45, 0);
    run_phase(16'($urandom), 8'($urandom), 0, 54, 45, 0);
    run_phase(16'($urandom), 8'($urandom), 35, 35, 45, 0);
    // The receiver holds off long enough for the block to fill and stall its input.
    run_phase(16'($urandom), 8'($urandom), 0, 0, 40, 300);
    run_phase(16'h0532, 8'h45, 35, 35, 40, 0);
    drain_frames();
    repeat (20) @(posedge clk);

    $display("Covered %0d command requests and %0d frame bytes over seven register settings,",
             cmds_sent, bytes_checked);
    $display("with free-running, sender-gap, receiver-stall, mixed and long hold-off phases.");
    if (error_count == 0) begin
      $display("scrambled_command_frame_encoder_top verification clean");
    end else begin
      $display("scrambled_command_frame_encoder_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("scrambled_command_frame_encoder_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire
